// ===== rtl/ccu_pkg.sv =====
// Shared constants for the combinatorics count unit: field widths, command
// and status codes, and the default result width. No dependencies.
package ccu_pkg;

  localparam int CMD_W = 3;
  localparam int CNT_W = 8;
  localparam int STATUS_W = 2;
  localparam int RESULT_BITS_DEF = 31;

  localparam logic [CMD_W-1:0] CMD_FACT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ARRANGE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHOOSE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POWER = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MULTISET = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

// ===== rtl/ccu_req_if.sv =====
// Request channel of the combinatorics count unit: valid/ready and the
// command with its two counts. Depends on ccu_pkg.
interface ccu_req_if;
  logic valid;
  logic ready;
  logic [ccu_pkg::CMD_W-1:0] cmd;
  logic [ccu_pkg::CNT_W-1:0] n;
  logic [ccu_pkg::CNT_W-1:0] k;

  modport source (output valid, output cmd, output n, output k, input ready);
  modport sink (input valid, input cmd, input n, input k, output ready);
endinterface

// ===== rtl/ccu_rsp_if.sv =====
// Response channel of the combinatorics count unit: valid/ready, the count
// and its status. Depends on ccu_pkg.
interface ccu_rsp_if #(
  parameter int RESULT_BITS = ccu_pkg::RESULT_BITS_DEF
);
  logic valid;
  logic ready;
  logic [RESULT_BITS-1:0] value;
  logic [ccu_pkg::STATUS_W-1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

// ===== rtl/combinatorics_count_unit.sv =====
// Exact factorial, arrangement, combination, power and multiset counts.
// Depends on ccu_pkg, ccu_req_if and ccu_rsp_if.
//
//   channel  dir  payload                 beat when
//   req      in   cmd[2:0] n[7:0] k[7:0]  req.valid && req.ready
//   rsp      out  value[RB-1:0] status    rsp.valid && rsp.ready
//
// One item at a time; req.ready is high only while the sequencer is idle.
// Invalid or trivial items go from idle straight to S_FIN and then to the
// output register. Falling products and powers run one multiply step per
// count (cnt = n or k) on the shared RB x 9 multiplier. Combinations run
// j = min(k, m - k) steps, each a multiply then a restoring division by the
// step index, one quotient bit a cycle. Overflow ends the loop at once.
// rsp is a held output register; a stalled rsp blocks only the final step.
// Synchronous reset clears the sequencer and the output valid.
module combinatorics_count_unit #(
  parameter int RESULT_BITS = ccu_pkg::RESULT_BITS_DEF
) (
  input logic clk,
  input logic rst,
  ccu_req_if.sink req,
  ccu_rsp_if.source rsp
);

  localparam int RB = RESULT_BITS;
  localparam int PW = RB + 9;
  localparam int BW = $clog2(PW + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL = 4'b0010,
    S_DIV = 4'b0100,
    S_FIN = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [RB-1:0] acc, acc_next;
  logic [8:0] fac, fac_next;
  logic [7:0] cnt, cnt_next;
  logic [7:0] divr, divr_next;
  logic [PW-1:0] dvd, dvd_next;
  logic [7:0] rem, rem_next;
  logic [BW-1:0] bcnt, bcnt_next;
  logic is_binom, is_binom_next;
  logic is_power, is_power_next;
  logic [RB-1:0] res_val, res_val_next;
  logic [1:0] res_st, res_st_next;
  logic ov, ov_next;
  logic [RB-1:0] oval, oval_next;
  logic [1:0] ost, ost_next;

  // setup decode
  logic [8:0] m9, mk9, j9;
  logic k_gt_n, invalid, trivial;
  logic [7:0] cnt_ld;
  // shared datapath
  logic [PW-1:0] prod;
  logic [8:0] rem_sh;
  logic ge;
  logic [PW-1:0] quo;
  logic out_free;

  assign prod = PW'(acc) * PW'(fac);
  assign rem_sh = {rem, dvd[PW-1]};
  assign ge = rem_sh >= {1'b0, divr};
  assign quo = {dvd[PW-2:0], ge};
  assign out_free = !ov || rsp.ready;

  always_comb begin
    k_gt_n = req.k > req.n;
    m9 = (req.cmd == ccu_pkg::CMD_MULTISET) ?
         9'({1'b0, req.n} + {1'b0, req.k} - 9'd1) : {1'b0, req.n};
    mk9 = m9 - {1'b0, req.k};
    j9 = ({1'b0, req.k} > mk9) ? mk9 : {1'b0, req.k};
    invalid = 1'b0;
    trivial = 1'b0;
    cnt_ld = req.k;
    unique case (req.cmd)
      ccu_pkg::CMD_FACT: cnt_ld = req.n;
      ccu_pkg::CMD_ARRANGE: invalid = k_gt_n;
      ccu_pkg::CMD_CHOOSE: begin
        invalid = k_gt_n;
        cnt_ld = j9[7:0];
      end
      ccu_pkg::CMD_POWER: trivial = req.n == '0;
      ccu_pkg::CMD_MULTISET: begin
        trivial = req.n == '0;
        cnt_ld = j9[7:0];
      end
      default: invalid = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    acc_next = acc;
    fac_next = fac;
    cnt_next = cnt;
    divr_next = divr;
    dvd_next = dvd;
    rem_next = rem;
    bcnt_next = bcnt;
    is_binom_next = is_binom;
    is_power_next = is_power;
    res_val_next = res_val;
    res_st_next = res_st;
    ov_next = ov && !rsp.ready;
    oval_next = oval;
    ost_next = ost;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          acc_next = RB'(1);
          fac_next = (req.cmd == ccu_pkg::CMD_POWER) ? {1'b0, req.n} : m9;
          cnt_next = cnt_ld;
          divr_next = 8'd1;
          is_binom_next = (req.cmd == ccu_pkg::CMD_CHOOSE) ||
                          (req.cmd == ccu_pkg::CMD_MULTISET);
          is_power_next = req.cmd == ccu_pkg::CMD_POWER;
          res_val_next = RB'(1);
          res_st_next = ccu_pkg::ST_OK;
          if (invalid) begin
            res_val_next = '0;
            res_st_next = ccu_pkg::ST_INVALID;
            state_next = S_FIN;
          end else if (trivial) begin
            res_val_next = RB'(req.k == '0);
            state_next = S_FIN;
          end else if (cnt_ld == '0) begin
            state_next = S_FIN;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (is_binom) begin
          dvd_next = prod;
          rem_next = '0;
          bcnt_next = BW'(PW);
          state_next = S_DIV;
        end else if (prod[PW-1:RB] != '0) begin
          res_val_next = '0;
          res_st_next = ccu_pkg::ST_OVERFLOW;
          state_next = S_FIN;
        end else begin
          acc_next = prod[RB-1:0];
          cnt_next = cnt - 8'd1;
          if (!is_power) fac_next = fac - 9'd1;
          if (cnt == 8'd1) begin
            res_val_next = prod[RB-1:0];
            state_next = S_FIN;
          end
        end
      end
      S_DIV: begin
        // one restoring quotient bit per cycle; the division is exact
        rem_next = ge ? 8'(rem_sh - {1'b0, divr}) : rem_sh[7:0];
        dvd_next = quo;
        bcnt_next = bcnt - BW'(1);
        if (bcnt == BW'(1)) begin
          if (quo[PW-1:RB] != '0) begin
            res_val_next = '0;
            res_st_next = ccu_pkg::ST_OVERFLOW;
            state_next = S_FIN;
          end else begin
            acc_next = quo[RB-1:0];
            cnt_next = cnt - 8'd1;
            fac_next = fac - 9'd1;
            divr_next = divr + 8'd1;
            if (cnt == 8'd1) begin
              res_val_next = quo[RB-1:0];
              state_next = S_FIN;
            end else begin
              state_next = S_MUL;
            end
          end
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          ov_next = 1'b1;
          oval_next = res_val;
          ost_next = res_st;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
    end
    acc <= acc_next;
    fac <= fac_next;
    cnt <= cnt_next;
    divr <= divr_next;
    dvd <= dvd_next;
    rem <= rem_next;
    bcnt <= bcnt_next;
    is_binom <= is_binom_next;
    is_power <= is_power_next;
    res_val <= res_val_next;
    res_st <= res_st_next;
    oval <= oval_next;
    ost <= ost_next;
  end

  assign req.ready = state == S_IDLE;
  assign rsp.valid = ov;
  assign rsp.value = oval;
  assign rsp.status = ost;

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ccu_pkg::ST_OK |-> rsp.value == '0)
    else $error("nonzero value with error status");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < divr && divr != '0)
    else $error("divider remainder out of range");

  a_bad_cmd_fin: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.cmd > ccu_pkg::CMD_MULTISET |=> state == S_FIN)
    else $error("bad command did not finish at once");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && (!rsp.valid || rsp.ready) |=> rsp.valid && state == S_IDLE)
    else $error("finished result not moved to output");

endmodule

// ===== sim/combinatorics_count_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for combinatorics_count_unit: drives command beats on req,
// checks every rsp beat against a built-in count predictor.
// Depends on ccu_pkg, ccu_req_if, ccu_rsp_if and the unit itself.
module combinatorics_count_unit_tb;

  localparam int CMD_W = ccu_pkg::CMD_W;
  localparam int CNT_W = ccu_pkg::CNT_W;
  localparam int STATUS_W = ccu_pkg::STATUS_W;
  localparam int RB = ccu_pkg::RESULT_BITS_DEF;
  localparam longint unsigned VALUE_MAX = (64'd1 << RB) - 64'd1;
  localparam int CMD_TOP = (1 << CMD_W) - 1;
  localparam int CNT_TOP = (1 << CNT_W) - 1;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASE_BEATS = 175;
  localparam int TAIL_CYCLES = 64;
  localparam int LIMIT_CYCLES = 2_000_000;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] k;
    bit drain_first;
  } count_req_t;

  typedef struct packed {
    logic [RB-1:0] value;
    logic [STATUS_W-1:0] status;
  } count_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ccu_req_if req ();
  ccu_rsp_if #(.RESULT_BITS(RB)) rsp ();

  combinatorics_count_unit #(.RESULT_BITS(RB)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  count_req_t pending_reqs[$];
  count_result_t expected_counts[$];
  int issued = 0;
  int received = 0;
  int failures = 0;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned mul_capped(longint unsigned a, longint unsigned b,
                                                 inout bit ovf);
    if (b != 0 && a > VALUE_MAX / b) begin
      ovf = 1'b1;
      return 0;
    end
    return a * b;
  endfunction

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // m * (m-1) * ... * (m-cnt+1), stop at the first overflow
  function automatic longint unsigned falling_product(longint unsigned m, longint unsigned cnt,
                                                      inout bit ovf);
    longint unsigned r = 1;
    for (longint unsigned i = 0; i < cnt && !ovf; i++)
      r = mul_capped(r, m - i, ovf);
    return r;
  endfunction

  // exact C(m,j); partial products stay below the final value
  function automatic longint unsigned choose_count(longint unsigned m, longint unsigned j,
                                                   inout bit ovf);
    longint unsigned r = 1;
    longint unsigned g;
    longint unsigned d;
    if (j > m - j)
      j = m - j;
    for (longint unsigned i = 0; i < j && !ovf; i++) begin
      g = gcd64(r, i + 1);
      d = (i + 1) / g;
      r = mul_capped(r / g, (m - i) / d, ovf);
    end
    return r;
  endfunction

  function automatic count_result_t predict_count(logic [CMD_W-1:0] cmd,
                                                  logic [CNT_W-1:0] n_in,
                                                  logic [CNT_W-1:0] k_in);
    longint unsigned n = n_in;
    longint unsigned k = k_in;
    longint unsigned val = 0;
    logic [STATUS_W-1:0] st = ccu_pkg::ST_OK;
    bit ovf = 1'b0;
    count_result_t res;
    case (cmd)
      ccu_pkg::CMD_FACT: val = falling_product(n, n, ovf);
      ccu_pkg::CMD_ARRANGE: begin
        if (k > n) st = ccu_pkg::ST_INVALID;
        else val = falling_product(n, k, ovf);
      end
      ccu_pkg::CMD_CHOOSE: begin
        if (k > n) st = ccu_pkg::ST_INVALID;
        else val = choose_count(n, k, ovf);
      end
      ccu_pkg::CMD_POWER: begin
        if (n == 0) begin
          val = (k == 0) ? 1 : 0;
        end else begin
          val = 1;
          for (longint unsigned i = 0; i < k && !ovf; i++)
            val = mul_capped(val, n, ovf);
        end
      end
      ccu_pkg::CMD_MULTISET: begin
        if (n == 0) val = (k == 0) ? 1 : 0;
        else val = choose_count(n + k - 1, k, ovf);
      end
      default: st = ccu_pkg::ST_INVALID;
    endcase
    if (st == ccu_pkg::ST_OK && ovf)
      st = ccu_pkg::ST_OVERFLOW;
    if (st != ccu_pkg::ST_OK)
      val = 0;
    res.value = val[RB-1:0];
    res.status = st;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic int sender_idle_pct(int beats);
    if (beats < PHASE_BEATS) return 14;
    if (beats < 2 * PHASE_BEATS) return 53;
    return 0;
  endfunction

  function automatic int receiver_stall_pct(int beats);
    if (beats < PHASE_BEATS) return 53;
    if (beats < 2 * PHASE_BEATS) return 14;
    return 0;
  endfunction

  task automatic add_request(logic [CMD_W-1:0] cmd, int n, int k, bit drain_first = 1'b0);
    count_req_t r;
    r.cmd = cmd;
    r.n = n[CNT_W-1:0];
    r.k = k[CNT_W-1:0];
    r.drain_first = drain_first;
    pending_reqs.push_back(r);
  endtask

  // Mostly small operands so that exact counts show up, some full-range noise.
  task automatic add_random_request(bit drain_first);
    logic [CMD_W-1:0] cmd;
    int n;
    int k;
    int span;
    if ($urandom_range(0, 99) < 6)
      cmd = CMD_W'($urandom_range(ccu_pkg::CMD_MULTISET + 1, CMD_TOP));
    else
      cmd = CMD_W'($urandom_range(ccu_pkg::CMD_FACT, ccu_pkg::CMD_MULTISET));
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, CNT_TOP) : $urandom_range(0, 40);
    span = (n < 10) ? n : 10;
    case ($urandom_range(0, 3))
      0: k = $urandom_range(0, CNT_TOP);
      1: k = $urandom_range(0, span);
      2: k = n - $urandom_range(0, span);
      default: k = $urandom_range(0, n);
    endcase
    add_request(cmd, n, k, drain_first);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive_req
    count_req_t item;
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_counts.push_back(predict_count(req.cmd, req.n, req.k));
        issued++;
      end
      if (!req.valid || req.ready) begin
        // hold a marked item back until the unit has flushed every result
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].drain_first && expected_counts.size() != 0) &&
            $urandom_range(0, 99) >= sender_idle_pct(issued)) begin
          item = pending_reqs.pop_front();
          req.valid <= 1'b1;
          req.cmd <= item.cmd;
          req.n <= item.n;
          req.k <= item.k;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : check_rsp
    count_result_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected rsp beat value %0d status %0d", $realtime,
                   rsp.value, rsp.status);
          failures++;
        end else begin
          want = expected_counts.pop_front();
          if (rsp.value !== want.value) begin
            $display("%0t: value mismatch, expected %0d got %0d", $realtime,
                     want.value, rsp.value);
            failures++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d got %0d", $realtime,
                     want.status, rsp.status);
            failures++;
          end
        end
        received++;
      end
      rsp.ready <= ($urandom_range(0, 99) >= receiver_stall_pct(received));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[combinatorics_count_unit] ERROR");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.cmd = ccu_pkg::CMD_FACT;
    req.n = '0;
    req.k = '0;
    rsp.ready = 1'b0;

    // field extremes and each boundary of the result width
    add_request(ccu_pkg::CMD_FACT, 0, CNT_TOP);
    add_request(ccu_pkg::CMD_FACT, 12, 0);
    add_request(ccu_pkg::CMD_FACT, 13, 0);
    add_request(ccu_pkg::CMD_FACT, CNT_TOP, CNT_TOP);
    add_request(ccu_pkg::CMD_ARRANGE, 5, 6);
    add_request(ccu_pkg::CMD_ARRANGE, CNT_TOP, 0);
    add_request(ccu_pkg::CMD_ARRANGE, CNT_TOP, 3);
    add_request(ccu_pkg::CMD_ARRANGE, CNT_TOP, CNT_TOP);
    add_request(ccu_pkg::CMD_CHOOSE, 3, 4);
    add_request(ccu_pkg::CMD_CHOOSE, CNT_TOP, CNT_TOP);
    add_request(ccu_pkg::CMD_CHOOSE, 33, 16);
    add_request(ccu_pkg::CMD_CHOOSE, 34, 17);
    add_request(ccu_pkg::CMD_CHOOSE, CNT_TOP, 128);
    add_request(ccu_pkg::CMD_POWER, 0, 0);
    add_request(ccu_pkg::CMD_POWER, 0, 5);
    add_request(ccu_pkg::CMD_POWER, 2, 30);
    add_request(ccu_pkg::CMD_POWER, 2, 31);
    add_request(ccu_pkg::CMD_POWER, 1, CNT_TOP);
    add_request(ccu_pkg::CMD_POWER, CNT_TOP, CNT_TOP);
    add_request(ccu_pkg::CMD_MULTISET, 0, 0);
    add_request(ccu_pkg::CMD_MULTISET, 0, 3);
    add_request(ccu_pkg::CMD_MULTISET, 1, CNT_TOP);
    add_request(ccu_pkg::CMD_MULTISET, CNT_TOP, CNT_TOP);
    for (int c = ccu_pkg::CMD_MULTISET + 1; c <= CMD_TOP; c++)
      add_request(CMD_W'(c), (c % 2 == 0) ? CNT_TOP : 0, (c % 2 == 0) ? 0 : CNT_TOP);

    for (int i = 0; i < RANDOM_ITEMS; i++)
      add_random_request(i % 120 == 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req.valid)
      @(posedge clk);
    while (expected_counts.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (failures == 0)
      $display("[combinatorics_count_unit] OK");
    else
      $display("[combinatorics_count_unit] ERROR");
    $finish;
  end

endmodule
